// ===== sv/b2d_pkg.sv =====
package b2d_pkg;

	// Width of the value field and number of low bits that take part.
	localparam int FIELD_BITS = 32;
	localparam int VALUE_BITS = 32;
	localparam int OP_BITS    = (VALUE_BITS > FIELD_BITS) ? FIELD_BITS : VALUE_BITS;

	// Decimal digits needed for OP_BITS bits (1233/4096 approximates log10(2)).
	localparam int NUM_DIGITS = (OP_BITS * 1233) / 4096 + 1;

	// Counter widths.
	localparam int CNT_W = $clog2(OP_BITS + 1);
	localparam int REM_W = $clog2(NUM_DIGITS + 1);

	// Stream widths and character constants.
	localparam int S_TDATA_W = 32;
	localparam int M_TDATA_W = 8;
	localparam int CHAR_W    = 6;
	localparam int BCD_W     = 4;
	localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;
	localparam logic [CHAR_W-1:0] ASCII_NINE = 6'd57;

	// Control that the sequencer drives into every digit cell.
	typedef struct packed {
		logic clear;     // start a new conversion
		logic conv;      // add-3 and shift one bit in
		logic shift_dig; // move whole digits one place toward the top
	} cell_ctrl_t;

endpackage

// ===== sv/binary_to_decimal_ascii_core.sv =====
// Sequence: after an input transfer, a shift-add-3 conversion over the 32 operand bits,
// then a pass that drops leading zeros, then the digits are offered one by one.
// Throughput: one value at a time; dropped zeros and digits always add up to 10, and a
// new value is taken only after the last digit of the previous one has been sent.
// The rate is set by the bit-serial pass through the digit cells, the skip and output stalls.
// Reset (arst_n low) returns the sequencer to idle; the digit cells are not reset.
module binary_to_decimal_ascii_core
	import b2d_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // [31:0] value
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,  // [5:0] digit_char, [7:6] zero
	output logic                 m_tlast   // last_digit
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CONV = 2'd1;
	localparam logic [1:0] ST_SKIP = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0]         state_q;
	logic [OP_BITS-1:0] shift_q;
	logic [CNT_W-1:0]   bit_cnt_q;
	logic [REM_W-1:0]   remain_q;
	cell_ctrl_t         ctrl;

	logic [NUM_DIGITS-1:0] bit_chain;
	logic [BCD_W-1:0]      dig_chain [NUM_DIGITS];
	logic [BCD_W-1:0]      top_dig;

	assign top_dig = dig_chain[NUM_DIGITS-1];

	// Row of digit cells, least significant at index 0.
	for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
		logic             cell_bit_in;
		logic [BCD_W-1:0] cell_dig_in;
		if (i == 0) begin : g_low
			assign cell_bit_in = shift_q[OP_BITS-1];
			assign cell_dig_in = '0;
		end else begin : g_mid
			assign cell_bit_in = bit_chain[i-1];
			assign cell_dig_in = dig_chain[i-1];
		end
		b2d_cell u_cell (
			.clk     (clk),
			.ctrl    (ctrl),
			.bit_in  (cell_bit_in),
			.dig_in  (cell_dig_in),
			.bit_out (bit_chain[i]),
			.dig     (dig_chain[i])
		);
	end

	// Handshake and cell control.
	always_comb begin
		s_tready       = (state_q == ST_IDLE);
		m_tvalid       = (state_q == ST_EMIT);
		m_tlast        = (remain_q == REM_W'(1));
		m_tdata        = {2'b00, ASCII_ZERO + {2'b00, top_dig}};
		ctrl.clear     = s_tvalid && s_tready;
		ctrl.conv      = (state_q == ST_CONV);
		ctrl.shift_dig = ((state_q == ST_SKIP) && (top_dig == '0) && (remain_q > REM_W'(1)))
			|| ((state_q == ST_EMIT) && m_tready);
	end

	// Operand shift register; its top bit feeds the lowest cell.
	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			shift_q <= s_tdata[OP_BITS-1:0];
		end else if (ctrl.conv) begin
			shift_q <= {shift_q[OP_BITS-2:0], 1'b0};
		end
	end

	// Sequencer: convert, drop leading zeros, then hand out digits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			bit_cnt_q <= '0;
			remain_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						bit_cnt_q <= CNT_W'(OP_BITS);
						state_q   <= ST_CONV;
					end
				end
				ST_CONV: begin
					bit_cnt_q <= bit_cnt_q - CNT_W'(1);
					if (bit_cnt_q == CNT_W'(1)) begin
						remain_q <= REM_W'(NUM_DIGITS);
						state_q  <= ST_SKIP;
					end
				end
				ST_SKIP: begin
					if (ctrl.shift_dig) begin
						remain_q <= remain_q - REM_W'(1);
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (m_tready) begin
						remain_q <= remain_q - REM_W'(1);
						if (remain_q == REM_W'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== sv/b2d_cell.sv =====
module b2d_cell
	import b2d_pkg::*;
(
	input  logic             clk,
	input  cell_ctrl_t       ctrl,
	input  logic             bit_in,
	input  logic [BCD_W-1:0] dig_in,
	output logic             bit_out,
	output logic [BCD_W-1:0] dig
);

	logic [BCD_W-1:0] dig_q;
	logic [BCD_W-1:0] adj;

	// Add 3 when the digit is five or more, so the next doubling carries out.
	always_comb begin
		adj = (dig_q >= 4'd5) ? (dig_q + 4'd3) : dig_q;
	end

	assign bit_out = adj[BCD_W-1];
	assign dig     = dig_q;

	// Digit register: cleared, shifted by one bit, or handed up a whole digit.
	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			dig_q <= '0;
		end else if (ctrl.conv) begin
			dig_q <= {adj[BCD_W-2:0], bit_in};
		end else if (ctrl.shift_dig) begin
			dig_q <= dig_in;
		end
	end

endmodule

// ===== sv/b2d_chk.sv =====
module b2d_chk
	import b2d_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic [S_TDATA_W-1:0] s_tdata,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata,
	input logic                 m_tlast
);

	// An input transfer closes the input until the number has been sent.
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input ready right after an input transfer");

	// Digits are never offered while a new value can be taken.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("output valid while input ready");

	// Every offered character is an ASCII decimal digit.
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[CHAR_W-1:0] >= ASCII_ZERO && m_tdata[CHAR_W-1:0] <= ASCII_NINE
			&& m_tdata[M_TDATA_W-1:CHAR_W] == '0))
		else $error("output character is not a decimal digit");

	// The output goes quiet after the last digit of a number.
	a_end_of_number: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> !m_tvalid)
		else $error("output valid after the last digit");

	// A stalled output transfer holds its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
		else $error("stalled output changed");

endmodule

bind binary_to_decimal_ascii_core b2d_chk u_b2d_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

// ===== sim/binary_to_decimal_ascii_core_tb.sv =====
`timescale 1ns / 100ps

module binary_to_decimal_ascii_core_tb;
	import b2d_pkg::*;

	// Holds the decimal characters still owed by the block, oldest first.
	class digit_scoreboard;
		typedef struct packed {
			logic [CHAR_W-1:0] ch;
			logic              last;
		} digit_t;

		digit_t pending_digits[$];
		int     values_noted;
		int     digits_checked;
		int     errors;

		// Split one accepted value into ASCII digits, most significant first.
		function void note_value(logic [S_TDATA_W-1:0] value);
			longint unsigned   v;
			longint unsigned   mask;
			logic [3:0]        rev[$];
			digit_t            d;
			v = value;
			mask = (OP_BITS >= 32) ? 64'hFFFF_FFFF : ((64'd1 << OP_BITS) - 1);
			v = v & mask;
			do begin
				rev.push_back(4'(v % 10));
				v = v / 10;
			end while (v != 0);
			for (int k = rev.size() - 1; k >= 0; k--) begin
				d.ch   = ASCII_ZERO + CHAR_W'(rev[k]);
				d.last = (k == 0);
				pending_digits.push_back(d);
			end
			values_noted++;
		endfunction

		// Compare one output transfer with the oldest owed digit.
		function void check_digit(logic [M_TDATA_W-1:0] data, logic last);
			digit_t d;
			if (pending_digits.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: unexpected digit data=%h last=%b", $realtime, data, last);
				return;
			end
			d = pending_digits.pop_front();
			digits_checked++;
			if (data !== {{(M_TDATA_W-CHAR_W){1'b0}}, d.ch} || last !== d.last) begin
				errors++;
				if (errors <= 10)
					$display("%0t: digit mismatch, expected data=%h last=%b, got data=%h last=%b",
						$realtime, {{(M_TDATA_W-CHAR_W){1'b0}}, d.ch}, d.last, data, last);
			end
		endfunction

		function int owed();
			return pending_digits.size();
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 m_tlast;

	digit_scoreboard sb = new();
	bit              steady = 1'b0;

	binary_to_decimal_ascii_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	// Idle length: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 50)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 40);
	endfunction

	// Offer one value and hold it until the input transfer completes.
	task automatic send_value(logic [S_TDATA_W-1:0] value);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		do @(posedge clk); while (!s_tready);
		sb.note_value(value);
	endtask

	// Random value with a random bit length, so short numbers show up often.
	function automatic logic [S_TDATA_W-1:0] random_value();
		logic [S_TDATA_W-1:0] v;
		int                   r;
		v = $urandom;
		r = $urandom_range(0, 9);
		if (r < 6)
			v = v >> $urandom_range(0, 31);
		else if (r < 8)
			v = 32'(64'd10 ** $urandom_range(0, 9)) - $urandom_range(0, 1);
		return v;
	endfunction

	// Receiver with random stalls.
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			gap = pick_gap();
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	// Every output transfer is checked against the owed digits.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_digit(m_tdata, m_tlast);
	end

	// Stimulus: directed corner values, a drain pause, then random values.
	initial begin
		logic [S_TDATA_W-1:0] corners[$];
		corners = {
			32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd101,
			32'd4294967295, 32'd4294967294, 32'd1000000000, 32'd999999999,
			32'h8000_0000, 32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA,
			32'd1234567890, 32'd4000000000, 32'd100000, 32'd65535, 32'd0
		};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (corners[i])
			send_value(corners[i]);

		// Hold the input until every owed digit has come out.
		s_tvalid <= 1'b0;
		do @(posedge clk); while (sb.owed() != 0);

		// A stretch with no idling on either side.
		steady = 1'b1;
		repeat (25)
			send_value(random_value());
		steady = 1'b0;

		repeat (75)
			send_value(random_value());

		s_tvalid <= 1'b0;
		do @(posedge clk); while (sb.owed() != 0);
		repeat (60) @(posedge clk);

		$display("Converted %0d values into %0d checked digits: zero, all ones, powers of ten,",
			sb.values_noted, sb.digits_checked);
		$display("random bit lengths, with and without stalls; %0d mismatches.", sb.errors);
		if (sb.errors == 0 && sb.owed() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Run limit, well above the slowest correct run.
	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
